FILE: rtl/signed_log_likelihood_pair_score_top_macros.svh
// Assertion helpers for the RTL file that checks its own logic (slps_back).
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef SIGNED_LOG_LIKELIHOOD_PAIR_SCORE_TOP_MACROS_SVH
`define SIGNED_LOG_LIKELIHOOD_PAIR_SCORE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLPS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slps assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slps assertion failed");

`endif

FILE: rtl/slps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slps_pkg;

	localparam int IN_WIDTH   = 40;
	localparam int EXP_WIDTH  = 56;
	localparam int EVID_WIDTH = 41;
	localparam int LN_BITS    = 48;
	localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_LEFT_ZERO   = 4'd1,
		ST_RIGHT_ZERO  = 4'd2,
		ST_PAIR_LEFT   = 4'd3,
		ST_PAIR_RIGHT  = 4'd4,
		ST_FLAG_MISM   = 4'd5,
		ST_LEFT_TOTAL  = 4'd6,
		ST_RIGHT_TOTAL = 4'd7,
		ST_CELL_EXCESS = 4'd8
	} status_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] p;
	} mul_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/slps_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module slps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/slps_front.sv
`timescale 1ns / 1ps
`default_nettype none
module slps_front #(
	parameter int COUNT_WIDTH = 40
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [COUNT_WIDTH-1:0]   left_total,
	input  logic [COUNT_WIDTH-1:0]   right_total,
	input  logic [COUNT_WIDTH-1:0]   joint_total,
	input  logic                     pair_seen,
	input  logic [COUNT_WIDTH-1:0]   corpus,
	input  logic                     q_pop,
	output logic                     q_empty,
	output logic [3*COUNT_WIDTH+3:0] q_data
);

	slps_pkg::status_t       status;
	logic [COUNT_WIDTH:0]    room;

	// Room left for the left count once the right-only cell is taken out.
	assign room = {1'b0, corpus} - {1'b0, right_total} + {1'b0, joint_total};

	always_comb begin
		priority if (left_total == '0) begin
			status = slps_pkg::ST_LEFT_ZERO;
		end else if (right_total == '0) begin
			status = slps_pkg::ST_RIGHT_ZERO;
		end else if (joint_total > left_total) begin
			status = slps_pkg::ST_PAIR_LEFT;
		end else if (joint_total > right_total) begin
			status = slps_pkg::ST_PAIR_RIGHT;
		end else if (pair_seen != (joint_total != '0)) begin
			status = slps_pkg::ST_FLAG_MISM;
		end else if (left_total > corpus) begin
			status = slps_pkg::ST_LEFT_TOTAL;
		end else if (right_total > corpus) begin
			status = slps_pkg::ST_RIGHT_TOTAL;
		end else if ({1'b0, left_total} > room) begin
			status = slps_pkg::ST_CELL_EXCESS;
		end else begin
			status = slps_pkg::ST_OK;
		end
	end

	slps_fifo #(
		.WIDTH(3 * COUNT_WIDTH + 4),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   ({status, joint_total, right_total, left_total}),
		.pop   (q_pop),
		.empty (q_empty),
		.dout  (q_data)
	);

endmodule
`default_nettype wire

FILE: rtl/slps_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module slps_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  slps_pkg::mul_req_t req,
	output slps_pkg::mul_rsp_t rsp
);

	logic [63:0]  a_q, b_q;
	logic [2:0]   step_q;
	logic [2:0]   prev;
	logic         busy_q, done_q;
	logic [63:0]  pp_s1;
	logic [127:0] acc_q;
	logic [127:0] pp_sh;
	logic [31:0]  a_half, b_half;

	// Partial products in order: low*low, low*high, high*low, high*high.
	assign a_half = step_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = step_q[0] ? b_q[63:32] : b_q[31:0];
	assign prev   = step_q - 3'd1;

	always_comb begin
		unique case (prev[1:0])
			2'd0:       pp_sh = {64'd0, pp_s1};
			2'd1, 2'd2: pp_sh = {32'd0, pp_s1, 32'd0};
			2'd3:       pp_sh = {pp_s1, 64'd0};
			default:    pp_sh = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q <= 3'd3) begin
				pp_s1 <= a_half * b_half;
			end
			if (step_q >= 3'd1) begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

endmodule
`default_nettype wire

FILE: rtl/slps_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "signed_log_likelihood_pair_score_top_macros.svh"
module slps_back #(
	parameter int COUNT_WIDTH   = 40,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	output logic                                q_pop,
	input  logic [3*COUNT_WIDTH+3:0]            q_data,
	input  logic [COUNT_WIDTH-1:0]              corpus,
	output slps_pkg::mul_req_t                  mul_req,
	input  slps_pkg::mul_rsp_t                  mul_rsp,
	output logic                                res_push,
	input  logic                                res_full,
	output logic [slps_pkg::EXP_WIDTH-1:0]      res_expected,
	output logic [slps_pkg::EVID_WIDTH-1:0]     res_evidence,
	output logic [3:0]                          res_status
);

	localparam int CW       = COUNT_WIDTH;
	localparam int DW       = 2 * COUNT_WIDTH + FRACTION_BITS;
	localparam int QW       = COUNT_WIDTH + FRACTION_BITS;
	localparam int SQ_SHIFT = slps_pkg::LN_BITS - 2 * FRACTION_BITS;
	localparam int LOG_ROUNDS = slps_pkg::LN_BITS;
	localparam int ROOT_STEPS = 64;
	localparam logic [3:0] CELL_NEG_FIRST = 4'd5;
	localparam logic [3:0] CELL_COUNT     = 4'd9;
	localparam logic [63:0] EMAX = 64'd1 << (slps_pkg::EVID_WIDTH - 1);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_LR   = 11'b00000000010,
		S_JN   = 11'b00000000100,
		S_DIV  = 11'b00000001000,
		S_CELL = 11'b00000010000,
		S_NORM = 11'b00000100000,
		S_SQ   = 11'b00001000000,
		S_LN   = 11'b00010000000,
		S_XL   = 11'b00100000000,
		S_ROOT = 11'b01000000000,
		S_DONE = 11'b10000000000
	} state_t;

	state_t            state_q;
	logic              mul_busy_q;
	logic [7:0]        cnt_q;
	logic [3:0]        cidx_q;
	logic [CW-1:0]     l_q, r_q, j_q;
	slps_pkg::status_t st_q;
	logic [127:0]      lr_q, jn_q;
	logic [DW-1:0]     dsh_q;
	logic [CW-1:0]     drem_q;
	logic [QW-1:0]     quo_q;
	logic [63:0]       m_q;
	logic [5:0]        k_q;
	logic [47:0]       frac_q;
	logic [63:0]       ln_q;
	logic [127:0]      pos_q, neg_q, v_q;
	logic [65:0]       rrem_q;
	logic [63:0]       root_q;

	slps_pkg::status_t q_status;
	logic              take;
	logic              in_mul;
	logic              done;
	logic [CW-1:0]     cval;
	logic [CW:0]       dtrial;
	logic              dge;
	logic [63:0]       sq;
	logic [127:0]      dpos, dval;
	logic [67:0]       rsh, rtrial;
	logic              rge;
	logic              sat_exp;
	logic [63:0]       cap_n, cap_p;
	logic [slps_pkg::EVID_WIDTH-1:0] neg_ev;

	assign q_status = slps_pkg::status_t'(q_data[3*CW+3:3*CW]);
	assign take     = (state_q == S_IDLE) && !q_empty;
	assign q_pop    = take;
	assign done     = mul_rsp.done;
	assign in_mul   = (state_q == S_LR) || (state_q == S_JN) || (state_q == S_SQ) ||
	                  (state_q == S_LN) || (state_q == S_XL);

	// The nine table cells: five enter the sum with a plus sign, four with a minus.
	always_comb begin
		unique case (cidx_q)
			4'd0:    cval = j_q;
			4'd1:    cval = l_q - j_q;
			4'd2:    cval = r_q - j_q;
			4'd3:    cval = corpus - r_q + j_q - l_q;
			4'd4:    cval = corpus;
			4'd5:    cval = l_q;
			4'd6:    cval = corpus - l_q;
			4'd7:    cval = r_q;
			4'd8:    cval = corpus - r_q;
			default: cval = '0;
		endcase
	end

	always_comb begin
		mul_req.start = in_mul && !mul_busy_q;
		unique case (state_q)
			S_LR: begin
				mul_req.a = 64'(l_q);
				mul_req.b = 64'(r_q);
			end
			S_JN: begin
				mul_req.a = 64'(j_q);
				mul_req.b = 64'(corpus);
			end
			S_SQ: begin
				mul_req.a = m_q;
				mul_req.b = m_q;
			end
			S_LN: begin
				mul_req.a = 64'({k_q, frac_q});
				mul_req.b = slps_pkg::LN2_Q62;
			end
			S_XL: begin
				mul_req.a = 64'(cval);
				mul_req.b = ln_q;
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	assign dtrial = {drem_q, dsh_q[DW-1]};
	assign dge    = dtrial >= {1'b0, corpus};
	assign sq     = mul_rsp.p[125:62];
	assign dpos   = pos_q - neg_q;
	assign dval   = (pos_q < neg_q) ? '0 : {dpos[126:0], 1'b0};
	assign rsh    = {rrem_q, v_q[127:126]};
	assign rtrial = {2'b00, root_q, 2'b01};
	assign rge    = rsh >= rtrial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mul_busy_q <= 1'b0;
			cnt_q      <= '0;
			cidx_q     <= '0;
		end else begin
			if (mul_req.start) begin
				mul_busy_q <= 1'b1;
			end else if (done) begin
				mul_busy_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= (q_status == slps_pkg::ST_OK) ? S_LR : S_DONE;
					end
				end
				S_LR: begin
					if (done) state_q <= S_JN;
				end
				S_JN: begin
					if (done) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'(DW - 1)) begin
						state_q <= S_CELL;
						cidx_q  <= '0;
					end
				end
				S_CELL: begin
					if (cidx_q == CELL_COUNT) begin
						state_q <= S_ROOT;
						cnt_q   <= '0;
					end else if (cval == '0) begin
						cidx_q <= cidx_q + 4'd1;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (m_q[62]) begin
						state_q <= S_SQ;
						cnt_q   <= '0;
					end
				end
				S_SQ: begin
					if (done) begin
						cnt_q <= cnt_q + 8'd1;
						if (cnt_q == 8'(LOG_ROUNDS - 1)) state_q <= S_LN;
					end
				end
				S_LN: begin
					if (done) state_q <= S_XL;
				end
				S_XL: begin
					if (done) begin
						state_q <= S_CELL;
						cidx_q  <= cidx_q + 4'd1;
					end
				end
				S_ROOT: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'(ROOT_STEPS - 1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					l_q   <= q_data[CW-1:0];
					r_q   <= q_data[2*CW-1:CW];
					j_q   <= q_data[3*CW-1:2*CW];
					st_q  <= q_status;
					pos_q <= '0;
					neg_q <= '0;
				end
			end
			S_LR: begin
				if (done) lr_q <= mul_rsp.p;
			end
			S_JN: begin
				if (done) begin
					jn_q   <= mul_rsp.p;
					dsh_q  <= {lr_q[2*CW-1:0], {FRACTION_BITS{1'b0}}};
					drem_q <= '0;
					quo_q  <= '0;
				end
			end
			S_DIV: begin
				dsh_q  <= {dsh_q[DW-2:0], 1'b0};
				drem_q <= dge ? CW'(dtrial - {1'b0, corpus}) : CW'(dtrial);
				quo_q  <= {quo_q[QW-2:0], dge};
			end
			S_CELL: begin
				if (cidx_q == CELL_COUNT) begin
					v_q    <= dval >> SQ_SHIFT;
					rrem_q <= '0;
					root_q <= '0;
				end else begin
					m_q    <= 64'(cval);
					k_q    <= 6'd62;
					frac_q <= '0;
				end
			end
			S_NORM: begin
				if (!m_q[62]) begin
					m_q <= {m_q[62:0], 1'b0};
					k_q <= k_q - 6'd1;
				end
			end
			S_SQ: begin
				if (done) begin
					m_q    <= sq[63] ? {1'b0, sq[63:1]} : sq;
					frac_q <= {frac_q[46:0], sq[63]};
				end
			end
			S_LN: begin
				if (done) ln_q <= mul_rsp.p[125:62];
			end
			S_XL: begin
				if (done) begin
					if (cidx_q < CELL_NEG_FIRST) pos_q <= pos_q + mul_rsp.p;
					else neg_q <= neg_q + mul_rsp.p;
				end
			end
			S_ROOT: begin
				v_q    <= {v_q[125:0], 2'b00};
				rrem_q <= rge ? 66'(rsh - rtrial) : 66'(rsh);
				root_q <= {root_q[62:0], rge};
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Result formatting with saturation on both numeric fields.
	assign sat_exp = (QW > slps_pkg::EXP_WIDTH) ? (|(quo_q >> slps_pkg::EXP_WIDTH)) : 1'b0;
	assign cap_n   = (root_q > EMAX) ? EMAX : root_q;
	assign cap_p   = (root_q > EMAX - 64'd1) ? EMAX - 64'd1 : root_q;
	assign neg_ev  = ~slps_pkg::EVID_WIDTH'(cap_n) + 1'b1;

	always_comb begin
		res_push   = (state_q == S_DONE) && !res_full;
		res_status = st_q;
		if (st_q != slps_pkg::ST_OK) begin
			res_expected = '0;
			res_evidence = '0;
		end else begin
			res_expected = sat_exp ? '1 : slps_pkg::EXP_WIDTH'(quo_q);
			if (jn_q < lr_q) res_evidence = neg_ev;
			else if (lr_q < jn_q) res_evidence = slps_pkg::EVID_WIDTH'(cap_p);
			else res_evidence = '0;
		end
	end

	`SLPS_ASSERT_SAME(a_err_zero, res_push && (res_status != slps_pkg::ST_OK), (res_expected == '0) && (res_evidence == '0))
	`SLPS_ASSERT_SAME(a_done_busy, mul_rsp.done, mul_busy_q && in_mul)
	`SLPS_ASSERT_NEXT(a_take_leaves, q_pop, state_q != S_IDLE)
	`SLPS_ASSERT_SAME(a_start_idle, mul_req.start, !mul_busy_q && !mul_rsp.done)

endmodule
`default_nettype wire

FILE: rtl/signed_log_likelihood_pair_score_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A transaction with a nonzero status skips the arithmetic: an idle engine sends it straight to the done
// state, which pushes it into the result queue. A valid item runs two products and the long division, then per
// nonzero cell a normalize step and 50 shared-multiplier passes, then the square root.
// Throughput is set by the single iterative back end and its 32x32 multiplier: it takes no new item
// until the last one is done; a two-deep queue on each side keeps both handshakes free meanwhile.
// Reset (arst_n low) empties both queues, idles the engine and sets corpus_size to 1.
module signed_log_likelihood_pair_score_top #(
	parameter int COUNT_WIDTH   = 40,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input queue side; a transaction moves when push is high and full is low.
	input  logic        push,
	output logic        full,
	input  logic [39:0] left_total,
	input  logic [39:0] right_total,
	input  logic [39:0] joint_total,
	input  logic        pair_seen,
	// Result queue side; a transaction moves when pop is high and empty is low.
	output logic        empty,
	input  logic        pop,
	output logic [55:0] expected_joint,
	output logic signed [40:0] signed_evidence,
	output logic [3:0]  status,
	// Configuration port; corpus_size lives at byte address 0.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int RES_W = slps_pkg::EXP_WIDTH + slps_pkg::EVID_WIDTH + 4;

	logic [COUNT_WIDTH-1:0]   corpus_q;
	logic                     q_empty, q_pop;
	logic [3*COUNT_WIDTH+3:0] q_data;
	slps_pkg::mul_req_t       mul_req;
	slps_pkg::mul_rsp_t       mul_rsp;
	logic                     res_push, res_full;
	logic [slps_pkg::EXP_WIDTH-1:0]  res_expected;
	logic [slps_pkg::EVID_WIDTH-1:0] res_evidence;
	logic [3:0]               res_status;
	logic [RES_W-1:0]         res_dout;

	// The register is written in the access phase of a write transaction. Bit 3 of the
	// address selects the register slot; only slot zero exists.
	assign pready = 1'b1;
	assign prdata = paddr[3] ? 64'd0 : 64'(corpus_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corpus_q <= COUNT_WIDTH'(1);
		end else if (psel && penable && pwrite && pready && !paddr[3]) begin
			corpus_q <= COUNT_WIDTH'(pwdata);
		end
	end

	// The front checks each item's counts against each other and the corpus total and queues it with its status.
	slps_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.left_total (COUNT_WIDTH'(left_total)),
		.right_total(COUNT_WIDTH'(right_total)),
		.joint_total(COUNT_WIDTH'(joint_total)),
		.pair_seen  (pair_seen),
		.corpus     (corpus_q),
		.q_pop      (q_pop),
		.q_empty    (q_empty),
		.q_data     (q_data)
	);

	// One shared multiplier serves every product the back end needs.
	slps_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mul_req),
		.rsp   (mul_rsp)
	);

	// The back end forms the expected count by long division, the log terms by repeated
	// squaring, and the evidence by a bit-serial square root.
	slps_back #(
		.COUNT_WIDTH  (COUNT_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_data      (q_data),
		.corpus      (corpus_q),
		.mul_req     (mul_req),
		.mul_rsp     (mul_rsp),
		.res_push    (res_push),
		.res_full    (res_full),
		.res_expected(res_expected),
		.res_evidence(res_evidence),
		.res_status  (res_status)
	);

	// Finished results wait here so the engine can move on to the next item.
	slps_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_results (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   ({res_expected, res_evidence, res_status}),
		.pop   (pop),
		.empty (empty),
		.dout  (res_dout)
	);

	assign expected_joint  = res_dout[RES_W-1:slps_pkg::EVID_WIDTH+4];
	assign signed_evidence = $signed(res_dout[slps_pkg::EVID_WIDTH+3:4]);
	assign status          = res_dout[3:0];

endmodule
`default_nettype wire
